### design/ptlb_pkg.sv
// ----------------------------------------------------------------------------
// ptlb_pkg
// Shared widths, register indexes, FSM codes and unit handshake structs of
// the pulse tachometer with its lagged bar display.
// ----------------------------------------------------------------------------
package ptlb_pkg;

   localparam int TPM_W     = 8;    // ticks_per_ms
   localparam int MS_W      = 16;   // millisecond counts and windows
   localparam int PULSE_W   = 32;   // pulse accumulator
   localparam int GAIN_W    = 16;   // rpm_gain
   localparam int RPM_W     = 16;   // rpm value
   localparam int LEVEL_W   = 6;    // bar levels
   localparam int REFRESH_W = 15;   // refresh_ticks
   localparam int RCOUNT_W  = 16;   // refresh counter
   localparam int CSR_W     = 16;   // widest register
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = PULSE_W + GAIN_W;

   // serial units: one multiplier bit / one quotient bit per cycle
   localparam int MUL_STEPS = GAIN_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [RPM_W-1:0] RPM_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_MS  = 3'd0,
      CSR_TIMEOUT_MS    = 3'd1,
      CSR_UPDATE_MS     = 3'd2,
      CSR_RPM_GAIN      = 3'd3,
      CSR_RPM_PER_STEP  = 3'd4,
      CSR_TOP_LEVEL     = 3'd5,
      CSR_REFRESH_TICKS = 3'd6
   } csr_index_type;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_FRONT   = 6'b000010,
      S_MUL     = 6'b000100,
      S_DIV_RPM = 6'b001000,
      S_LVL     = 6'b010000,
      S_DIV_LVL = 6'b100000
   } state_type;

   typedef struct packed {
      logic               start;
      logic [PULSE_W-1:0] a;
      logic [GAIN_W-1:0]  b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] hi;       // must be below divisor
      logic [DIV_W-1:0] lo;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

### design/ptlb_if.sv
// ----------------------------------------------------------------------------
// ptlb_if
// Valid/ready channels of the tachometer: sample beats in, result beats out.
// ----------------------------------------------------------------------------
interface ptlb_req_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic display_tick;

   modport source (output valid, pin_level, display_tick, input ready);
   modport sink   (input valid, pin_level, display_tick, output ready);
endinterface

interface ptlb_rsp_if
   import ptlb_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [RPM_W-1:0]   rpm;
   logic               rpm_updated;
   logic [LEVEL_W-1:0] level_now;
   logic [LEVEL_W-1:0] level_shown;

   modport source (output valid, rpm, rpm_updated, level_now, level_shown, input ready);
   modport sink   (input valid, rpm, rpm_updated, level_now, level_shown, output ready);
endinterface

### design/pulse_tachometer_with_lagged_bar.sv
// ----------------------------------------------------------------------------
// pulse_tachometer_with_lagged_bar
// Pulse tachometer: millisecond prescaler, edge-based pulse and time
// accumulation, serial rpm computation and a lagged bar level display.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one sample beat per sample tick (pin_level, display_tick);
//   rsp_if returns exactly one result beat per sample beat, in order.
//   csr_wr_en/csr_index/csr_wdata write the seven setup registers; write
//   them only while no sample beat is outstanding.
// Sequencing, one sample at a time (input is ready again the cycle after
//   the result beat is loaded):
//   an accepted sample passes the front stage, then the level stage loads
//   the result beat; a new rpm is formed by a shift-add multiply, then a
//   restoring divide by the accumulated milliseconds;
//   re-deriving the bar level uses the same divider (rpm over
//   rpm_per_step); it follows each new rpm and any register write.
// The result register frees the input side: a new sample is accepted while
//   the last result still waits; the block holds its next result until the
//   receiver takes the waiting one.
// Reset (synchronous, active high) loads the register defaults and clears all
//   counters, accumulators and the shown level.
// ----------------------------------------------------------------------------
module pulse_tachometer_with_lagged_bar
   import ptlb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ptlb_req_if.sink             req_if,
   ptlb_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // setup registers
   logic [TPM_W-1:0]     ticks_per_ms_ff;
   logic [MS_W-1:0]      timeout_ms_ff;
   logic [MS_W-1:0]      update_ms_ff;
   logic [GAIN_W-1:0]    rpm_gain_ff;
   logic [RPM_W-1:0]     rpm_per_step_ff;
   logic [LEVEL_W-1:0]   top_level_ff;
   logic [REFRESH_W-1:0] refresh_ticks_ff;

   // measurement and display state
   state_type            state_ff, state_in;
   logic                 pin_ff, pin_in;
   logic                 dtick_ff, dtick_in;
   logic [TPM_W-1:0]     prescale_ff, prescale_in;
   logic                 prev_pin_ff, prev_pin_in;
   logic [MS_W-1:0]      run_ms_ff, run_ms_in;
   logic [MS_W-1:0]      acc_ms_ff, acc_ms_in;
   logic [PULSE_W-1:0]   acc_pulses_ff, acc_pulses_in;
   logic [MS_W-1:0]      den_ff, den_in;
   logic [RPM_W-1:0]     rpm_ff, rpm_in;
   logic                 upd_ff, upd_in;
   logic                 dirty_ff, dirty_in;
   logic [RPM_W-1:0]     step_q_ff, step_q_in;
   logic [LEVEL_W-1:0]   shown_ff, shown_in;
   logic                 shown_init_ff, shown_init_in;
   logic [RCOUNT_W-1:0]  refresh_ff, refresh_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]     rsp_rpm_ff, rsp_rpm_in;
   logic                 rsp_upd_ff, rsp_upd_in;
   logic [LEVEL_W-1:0]   rsp_now_ff, rsp_now_in;
   logic [LEVEL_W-1:0]   rsp_shown_ff, rsp_shown_in;

   mul_req_type          mul_req;
   mul_rsp_type          mul_rsp;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // front-end path
   logic [TPM_W-1:0]     prescale_inc;
   logic                 ms_tick;
   logic [TPM_W-1:0]     prescale_next;
   logic [MS_W-1:0]      run_ms_inc;
   logic                 timeout;
   logic [MS_W-1:0]      run_ms_kept;
   logic                 rise;
   logic [PULSE_W-1:0]   acc_pulses_next;
   logic [MS_W:0]        acc_ms_sum;
   logic [MS_W-1:0]      acc_ms_next;
   logic [MS_W-1:0]      run_ms_next;
   logic                 calc;
   logic                 rpm_sat;

   // display path
   logic [LEVEL_W-1:0]   level_now;
   logic [RCOUNT_W-1:0]  refresh_inc;
   logic [LEVEL_W-1:0]   shown_base;
   logic [LEVEL_W-1:0]   level_dist;
   logic [RCOUNT_W-1:0]  threshold;
   logic                 step_go;
   logic [RCOUNT_W-1:0]  refresh_next;
   logic [LEVEL_W-1:0]   shown_next;
   logic                 rsp_load;

   ptlb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   ptlb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // prescaler, timeout and rising-edge accumulation
   always_comb begin
      prescale_inc  = prescale_ff + 1'b1;
      ms_tick       = prescale_inc >= ticks_per_ms_ff;
      prescale_next = ms_tick ? '0 : prescale_inc;
      run_ms_inc    = (ms_tick && run_ms_ff != '1) ? run_ms_ff + 1'b1 : run_ms_ff;
      timeout       = ms_tick && (run_ms_inc >= timeout_ms_ff);
      run_ms_kept   = timeout ? '0 : run_ms_inc;
      rise          = pin_ff && !prev_pin_ff;
      acc_pulses_next = (rise && acc_pulses_ff != '1) ? acc_pulses_ff + 1'b1
                                                      : acc_pulses_ff;
      acc_ms_sum    = {1'b0, acc_ms_ff} + (rise ? {1'b0, run_ms_kept} : '0);
      acc_ms_next   = acc_ms_sum[MS_W] ? '1 : acc_ms_sum[MS_W-1:0];
      run_ms_next   = rise ? '0 : run_ms_kept;
      calc          = (acc_ms_next >= update_ms_ff) || timeout;
      // quotient overflows 16 bits when the product's upper part reaches the divisor
      rpm_sat       = (mul_rsp.product[PROD_W-1:2*DIV_W] != '0) ||
                      (mul_rsp.product[2*DIV_W-1:DIV_W] >= den_ff);
   end

   // bar level and lagged display step
   always_comb begin
      level_now   = (step_q_ff > RPM_W'(top_level_ff)) ? top_level_ff
                                                       : step_q_ff[LEVEL_W-1:0];
      refresh_inc = (dtick_ff && refresh_ff != '1) ? refresh_ff + 1'b1 : refresh_ff;
      shown_base  = shown_init_ff ? shown_ff : level_now;
      level_dist  = (level_now > shown_base) ? level_now - shown_base
                                             : shown_base - level_now;
      // hold twice as long when within one step of a nonzero target
      threshold   = (level_now != '0 && level_dist <= LEVEL_W'(1))
                    ? {refresh_ticks_ff, 1'b0} : {1'b0, refresh_ticks_ff};
      step_go      = refresh_inc >= threshold;
      refresh_next = step_go ? '0 : refresh_inc;
      shown_next   = shown_base;
      if (step_go) begin
         if (shown_base < level_now) begin
            shown_next = shown_base + 1'b1;
         end else if (shown_base > level_now) begin
            shown_next = shown_base - 1'b1;
         end
      end
   end

   assign rsp_load = (state_ff == S_LVL) && !dirty_ff && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in      = state_ff;
      pin_in        = pin_ff;
      dtick_in      = dtick_ff;
      prescale_in   = prescale_ff;
      prev_pin_in   = prev_pin_ff;
      run_ms_in     = run_ms_ff;
      acc_ms_in     = acc_ms_ff;
      acc_pulses_in = acc_pulses_ff;
      den_in        = den_ff;
      rpm_in        = rpm_ff;
      upd_in        = upd_ff;
      dirty_in      = dirty_ff;
      step_q_in     = step_q_ff;
      shown_in      = shown_ff;
      shown_init_in = shown_init_ff;
      refresh_in    = refresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_shown_in  = rsp_shown_ff;
      mul_req       = '0;
      div_req       = '0;
      req_if.ready  = 1'b0;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               pin_in   = req_if.pin_level;
               dtick_in = req_if.display_tick;
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            prescale_in = prescale_next;
            prev_pin_in = pin_ff;
            run_ms_in   = run_ms_next;
            upd_in      = calc;
            state_in    = S_LVL;
            if (!calc) begin
               acc_ms_in     = acc_ms_next;
               acc_pulses_in = acc_pulses_next;
            end else begin
               acc_ms_in     = '0;
               acc_pulses_in = '0;
               dirty_in      = 1'b1;
               if (timeout) begin
                  rpm_in = '0;
               end else if (acc_ms_next == '0) begin
                  rpm_in = (acc_pulses_next != '0) ? RPM_MAX : '0;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = acc_pulses_next;
                  mul_req.b     = rpm_gain_ff;
                  den_in        = acc_ms_next;
                  state_in      = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_rsp.done) begin
               if (rpm_sat) begin
                  rpm_in   = RPM_MAX;
                  state_in = S_LVL;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.hi      = mul_rsp.product[2*DIV_W-1:DIV_W];
                  div_req.lo      = mul_rsp.product[DIV_W-1:0];
                  div_req.divisor = den_ff;
                  state_in        = S_DIV_RPM;
               end
            end
         end
         S_DIV_RPM: begin
            if (div_rsp.done) begin
               rpm_in   = div_rsp.quotient;
               state_in = S_LVL;
            end
         end
         S_LVL: begin
            if (dirty_ff) begin
               if (rpm_per_step_ff == '0) begin
                  step_q_in = (rpm_ff != '0) ? RPM_MAX : '0;
                  dirty_in  = 1'b0;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.hi      = '0;
                  div_req.lo      = rpm_ff;
                  div_req.divisor = rpm_per_step_ff;
                  state_in        = S_DIV_LVL;
               end
            end else if (rsp_load) begin
               refresh_in    = refresh_next;
               shown_in      = shown_next;
               shown_init_in = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_rpm_in    = rpm_ff;
               rsp_upd_in    = upd_ff;
               rsp_now_in    = level_now;
               rsp_shown_in  = shown_next;
               state_in      = S_IDLE;
            end
         end
         S_DIV_LVL: begin
            if (div_rsp.done) begin
               step_q_in = div_rsp.quotient;
               dirty_in  = 1'b0;
               state_in  = S_LVL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // any setup change may move the bar level
      if (csr_wr_en) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_ms_ff  <= TPM_W'(20);
         timeout_ms_ff    <= MS_W'(1000);
         update_ms_ff     <= MS_W'(500);
         rpm_gain_ff      <= GAIN_W'(60000);
         rpm_per_step_ff  <= RPM_W'(500);
         top_level_ff     <= LEVEL_W'(24);
         refresh_ticks_ff <= REFRESH_W'(100);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TICKS_PER_MS:  ticks_per_ms_ff  <= csr_wdata[TPM_W-1:0];
            CSR_TIMEOUT_MS:    timeout_ms_ff    <= csr_wdata[MS_W-1:0];
            CSR_UPDATE_MS:     update_ms_ff     <= csr_wdata[MS_W-1:0];
            CSR_RPM_GAIN:      rpm_gain_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_RPM_PER_STEP:  rpm_per_step_ff  <= csr_wdata[RPM_W-1:0];
            CSR_TOP_LEVEL:     top_level_ff     <= csr_wdata[LEVEL_W-1:0];
            CSR_REFRESH_TICKS: refresh_ticks_ff <= csr_wdata[REFRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pin_ff       <= pin_in;
      dtick_ff     <= dtick_in;
      den_ff       <= den_in;
      upd_ff       <= upd_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_now_ff   <= rsp_now_in;
      rsp_shown_ff <= rsp_shown_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         prescale_ff   <= '0;
         prev_pin_ff   <= 1'b0;
         run_ms_ff     <= '0;
         acc_ms_ff     <= '0;
         acc_pulses_ff <= '0;
         rpm_ff        <= '0;
         dirty_ff      <= 1'b0;
         step_q_ff     <= '0;
         shown_ff      <= '0;
         shown_init_ff <= 1'b0;
         refresh_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prescale_ff   <= prescale_in;
         prev_pin_ff   <= prev_pin_in;
         run_ms_ff     <= run_ms_in;
         acc_ms_ff     <= acc_ms_in;
         acc_pulses_ff <= acc_pulses_in;
         rpm_ff        <= rpm_in;
         dirty_ff      <= dirty_in;
         step_q_ff     <= step_q_in;
         shown_ff      <= shown_in;
         shown_init_ff <= shown_init_in;
         refresh_ff    <= refresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.rpm         = rsp_rpm_ff;
   assign rsp_if.rpm_updated = rsp_upd_ff;
   assign rsp_if.level_now   = rsp_now_ff;
   assign rsp_if.level_shown = rsp_shown_ff;

   // multiplier finishes only while the FSM waits on it
   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_MUL)
      else $error("multiplier done outside multiply phase");

   // divider finishes only while the FSM waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_RPM || state_ff == S_DIV_LVL))
      else $error("divider done outside divide phase");

   // a new result beat comes only from a finished level stage
   a_rsp_from_lvl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_LVL && state_ff == S_IDLE))
      else $error("result beat raised outside the level stage");

   // an accepted sample beat moves on to the front stage next cycle
   a_accept_to_front: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> state_ff == S_FRONT)
      else $error("accepted sample beat did not enter the front stage");

endmodule

### design/ptlb_mul.sv
// ----------------------------------------------------------------------------
// ptlb_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, product
// held until the next start.
// ----------------------------------------------------------------------------
module ptlb_mul
   import ptlb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [PULSE_W-1:0]   a_ff, a_in;
   logic [PULSE_W-1:0]   hi_ff, hi_in;
   logic [GAIN_W-1:0]    lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [PULSE_W:0]     sum;

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (req.start) begin
         a_in    = req.a;
         hi_in   = '0;
         lo_in   = req.b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add, then shift the pair right one place
         hi_in  = sum[PULSE_W:1];
         lo_in  = {sum[0], lo_ff[GAIN_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = {hi_ff, lo_ff};

endmodule

### design/ptlb_div.sv
// ----------------------------------------------------------------------------
// ptlb_div
// Restoring divider, one quotient bit per cycle. Divides {hi, lo} by the
// divisor where hi is below the divisor, so the quotient fits DIV_W bits.
// ----------------------------------------------------------------------------
module ptlb_div
   import ptlb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;   // dividend bits out, quotient bits in
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      if (req.start) begin
         rem_in  = req.hi;
         quo_in  = req.lo;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
